// ===== src/hmq_pkg.sv =====
// Package for the binary min-heap queue: widths, codes and sequencer states.
`default_nettype none

package hmq_pkg;

  // Default heap capacity in entries
  localparam int unsigned CAPACITY_DEF  = 64;

  // Fixed field widths
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ENTRY_TOTAL_W = 7;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_TDATA_W   = 72;

  // Operation selector carried in s_axis_tuser
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  // Result status carried in m_axis_tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_RD,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== src/hmq_store.sv =====
// Heap entry memory: one write port, two registered read ports.
`default_nettype none

module hmq_store #(
  parameter int unsigned CAPACITY = hmq_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [AW-1:0]                     waddr_i,
  input  wire logic signed [hmq_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]                     raddr0_i,
  input  wire logic [AW-1:0]                     raddr1_i,
  output logic signed [hmq_pkg::DATA_W-1:0]      rdata0_o,
  output logic signed [hmq_pkg::DATA_W-1:0]      rdata1_o
);
  import hmq_pkg::*;

  logic signed [DATA_W-1:0] mem_q [CAPACITY];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

// ===== src/hmq_ctrl.sv =====
// Heap sequencer: sift-up and sift-down walks, a child compare for sift-down, plus result register.
`default_nettype none

module hmq_ctrl #(
  parameter int unsigned CAPACITY = hmq_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input items
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  in_kind_i,
  input  wire logic signed [hmq_pkg::DATA_W-1:0]     in_value_i,
  // result items
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [hmq_pkg::DATA_W-1:0]          out_popped_o,
  output logic signed [hmq_pkg::DATA_W-1:0]          out_top_o,
  output logic                                       out_top_valid_o,
  output logic [hmq_pkg::ENTRY_TOTAL_W-1:0]          out_total_o,
  output logic [hmq_pkg::STATUS_W-1:0]               out_status_o,
  // memory side
  output logic                                       we_o,
  output logic [AW-1:0]                              waddr_o,
  output logic signed [hmq_pkg::DATA_W-1:0]          wdata_o,
  output logic [AW-1:0]                              raddr0_o,
  output logic [AW-1:0]                              raddr1_o,
  input  wire logic signed [hmq_pkg::DATA_W-1:0]     rdata0_i,
  input  wire logic signed [hmq_pkg::DATA_W-1:0]     rdata1_i
);
  import hmq_pkg::*;

  // child index needs room for 2*pos+2
  localparam int unsigned XW = AW + 2;

  state_e                   state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [XW-1:0]            child_q, child_d;
  logic signed [DATA_W-1:0] moving_q, moving_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] top_q;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_popped_q, out_top_q;
  logic                     out_top_valid_q;
  logic [ENTRY_TOTAL_W-1:0] out_total_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic                     load_out;

  logic [AW-1:0]            parent;
  logic [XW-1:0]            child_r;
  logic [XW-1:0]            cnt_x;
  logic                     take_right;
  logic signed [DATA_W-1:0] cval;
  logic [AW-1:0]            cidx;
  logic [CW+ENTRY_TOTAL_W-1:0] total_ext;

  assign parent     = AW'((pos_q - AW'(1)) >> 1);
  assign child_r    = XW'(child_q + XW'(1));
  assign cnt_x      = XW'(cnt_q);
  // child compare: pick smaller child, left on a tie
  assign take_right = (child_r < cnt_x) && (rdata1_i < rdata0_i);
  assign cval       = take_right ? rdata1_i : rdata0_i;
  assign cidx       = take_right ? child_r[AW-1:0] : child_q[AW-1:0];
  assign total_ext  = {{ENTRY_TOTAL_W{1'b0}}, cnt_q};

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state, memory requests
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    child_d  = child_q;
    moving_d = moving_q;
    popped_d = popped_q;
    status_d = status_q;
    we_o     = 1'b0;
    waddr_o  = pos_q;
    wdata_o  = moving_q;
    raddr0_o = child_q[AW-1:0];
    raddr1_o = child_r[AW-1:0];
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          popped_d = '0;
          status_d = STAT_OK;
          if (in_kind_i == KIND_INSERT) begin
            if (cnt_q >= CW'(CAPACITY)) begin
              status_d = STAT_FULL;
              state_d  = ST_DONE;
            end else begin
              pos_d    = cnt_q[AW-1:0];
              moving_d = in_value_i;
              state_d  = ST_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = STAT_EMPTY;
              state_d  = ST_DONE;
            end else begin
              popped_d = top_q;
              cnt_d    = CW'(cnt_q - CW'(1));
              state_d  = ST_POP_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_q == '0) begin
          we_o    = 1'b1;
          cnt_d   = CW'(cnt_q + CW'(1));
          state_d = ST_DONE;
        end else begin
          raddr0_o = parent;
          state_d  = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we_o = 1'b1;
        if (rdata0_i > moving_q) begin
          wdata_o = rdata0_i;
          pos_d   = parent;
          state_d = ST_UP_RD;
        end else begin
          cnt_d   = CW'(cnt_q + CW'(1));
          state_d = ST_DONE;
        end
      end
      ST_POP_RD: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          raddr0_o = cnt_q[AW-1:0];
          state_d  = ST_POP_LD;
        end
      end
      ST_POP_LD: begin
        moving_d = rdata0_i;
        pos_d    = '0;
        child_d  = XW'(1);
        state_d  = ST_DN_RD;
      end
      ST_DN_RD: begin
        if (child_q >= cnt_x) begin
          we_o    = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        we_o = 1'b1;
        if (cval >= moving_q) begin
          state_d = ST_DONE;
        end else begin
          wdata_o = cval;
          pos_d   = cidx;
          child_d = XW'({cidx, 1'b1});
          state_d = ST_DN_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Work and payload registers
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    child_q  <= child_d;
    moving_q <= moving_d;
    popped_q <= popped_d;
    status_q <= status_d;
    // root copy tracks every write to entry zero
    if (we_o && (waddr_o == '0)) begin
      top_q <= wdata_o;
    end
    if (load_out) begin
      out_popped_q    <= popped_q;
      out_top_q       <= (cnt_q != '0) ? top_q : '0;
      out_top_valid_q <= (cnt_q != '0);
      out_total_q     <= total_ext[ENTRY_TOTAL_W-1:0];
      out_status_q    <= status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_popped_o    = out_popped_q;
  assign out_top_o       = out_top_q;
  assign out_top_valid_o = out_top_valid_q;
  assign out_total_o     = out_total_q;
  assign out_status_o    = out_status_q;

endmodule

`default_nettype wire

// ===== src/binary_min_heap_queue.sv =====
// Top level of the binary min-heap priority queue with stream ports.
//
// Input channel (s_axis): one item is one operation. s_axis_tuser selects it
// (0 insert, 1 pop minimum), s_axis_tdata carries the value to insert.
// Output channel (m_axis): one result item per operation: popped value, new
// minimum, its valid flag and the entry count in tdata, the status code
// (ok, pop on empty, insert when full) in tuser.
// The block works on one item at a time; s_axis_tready is high only while
// the sequencer is idle. An insert reads the parent, then compares and
// writes, per level, until it reaches the root or a parent no larger than
// the value. A pop reads the last entry, then walks down, reading both
// children, then comparing against the smaller and writing, per level,
// until it runs out of children or no child is smaller. A pop that leaves
// the heap empty and a refused insert or pop skip the walk. The result is
// registered and becomes valid as s_axis_tready rises again.
// The result waits in an output register; a new item is taken while it is
// held, and a later result waits in the sequencer until m_axis_tready.
// Reset empties the heap at once (entry count to zero); the memory needs no
// clearing, since only written entries are read.
`default_nettype none

module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = hmq_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [31:0] value
  input  wire logic [hmq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] kind
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [31:0] popped_value, [63:32] top_value, [64] top_valid, [71:65] entry_total
  output logic [hmq_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // [1:0] status
  output logic [hmq_pkg::STATUS_W-1:0]             m_axis_tuser
);
  import hmq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                     we;
  logic [AW-1:0]            waddr, raddr0, raddr1;
  logic signed [DATA_W-1:0] wdata, rdata0, rdata1;
  logic signed [DATA_W-1:0] popped, top;
  logic                     top_valid;
  logic [ENTRY_TOTAL_W-1:0] total;
  logic [STATUS_W-1:0]      status;

  hmq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_kind_i       (s_axis_tuser),
    .in_value_i      (s_axis_tdata[DATA_W-1:0]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_popped_o    (popped),
    .out_top_o       (top),
    .out_top_valid_o (top_valid),
    .out_total_o     (total),
    .out_status_o    (status),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .raddr0_o        (raddr0),
    .raddr1_o        (raddr1),
    .rdata0_i        (rdata0),
    .rdata1_i        (rdata1)
  );

  hmq_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // Result packing
  assign m_axis_tdata = {total, top_valid, top, popped};
  assign m_axis_tuser = status;

`ifndef SYNTHESIS
  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // Failed pop removes nothing and reports an empty heap
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_EMPTY) |->
      (popped == '0) && !top_valid)
    else $error("pop on empty reports data");

  // Full insert leaves a non-empty heap
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_FULL) |-> top_valid)
    else $error("insert when full reports empty heap");

  // Empty heap shows a zero minimum
  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !top_valid |-> (top == '0))
    else $error("empty heap shows nonzero minimum");
`endif

endmodule

`default_nettype wire
